FILE: sv/c_escape_string_decoder_defines.svh
// ----------------------------------------------------------------------------
// C escape string decoder assertion macros
// Shared property wrappers, clocked on clk and disabled during reset.
// ----------------------------------------------------------------------------
`ifndef C_ESCAPE_STRING_DECODER_DEFINES_SVH
`define C_ESCAPE_STRING_DECODER_DEFINES_SVH

`define CESD_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

`define CESD_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) ante |=> cons) else $error(msg);

`endif

FILE: sv/cesd_pkg.sv
// ----------------------------------------------------------------------------
// C escape string decoder package
// Character codes, decode modes and the command passed from front to back.
// ----------------------------------------------------------------------------
package cesd_pkg;

  typedef enum logic [3:0] {
    MODE_NORMAL = 4'b0001,
    MODE_ESCAPE = 4'b0010,
    MODE_OCTAL  = 4'b0100,
    MODE_HEX    = 4'b1000
  } mode_t;

  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_QUOTE  = 8'h22;
  localparam logic [7:0] CH_N      = 8'h6E;
  localparam logic [7:0] CH_T      = 8'h74;
  localparam logic [7:0] CH_R      = 8'h72;
  localparam logic [7:0] CH_B      = 8'h62;
  localparam logic [7:0] CH_X      = 8'h78;
  localparam logic [7:0] CH_0      = 8'h30;
  localparam logic [7:0] CH_7      = 8'h37;
  localparam logic [7:0] CH_8      = 8'h38;
  localparam logic [7:0] CH_9      = 8'h39;
  localparam logic [7:0] CH_LA     = 8'h61;
  localparam logic [7:0] CH_LF     = 8'h66;
  localparam logic [7:0] CH_UA     = 8'h41;
  localparam logic [7:0] CH_UF     = 8'h46;
  localparam logic [7:0] BYTE_NL   = 8'h0A;
  localparam logic [7:0] BYTE_TAB  = 8'h09;

  localparam int unsigned Q_DEPTH = 2;
  localparam int unsigned Q_PW    = $clog2(Q_DEPTH);
  localparam int unsigned Q_CW    = $clog2(Q_DEPTH + 1);

  typedef struct packed {
    logic       pa_en;
    logic [7:0] pa_val;
    logic       pb_en;
    logic [7:0] pb_val;
    logic       pop;
    logic       flush;
  } cmd_t;

  // Returns {valid, digit value} for a hexadecimal character.
  function automatic logic [4:0] hex_digit(input logic [7:0] c);
    logic [4:0] r;
    r = '0;
    if (c >= CH_0 && c <= CH_9) begin
      r = {1'b1, c[3:0]};
    end else if ((c >= CH_LA && c <= CH_LF) || (c >= CH_UA && c <= CH_UF)) begin
      r = {1'b1, 4'(c[3:0] + 4'd9)};
    end
    return r;
  endfunction

endpackage

FILE: sv/c_escape_string_decoder.sv
// ----------------------------------------------------------------------------
// C escape string decoder
// Decodes C style escapes in a byte stream, one raw byte per input request.
// Input requests carry in_byte and in_last on in_valid; the block pushes back
// with in_stall. Result requests carry out_byte, out_valid and out_last on
// out_req_valid and are held while out_stall is high.
// Decoded bytes sit in a hold stack of HOLD_DEPTH entries; a push into a full
// stack sends its oldest byte out. The request with in_last flushes the stack,
// oldest first, or sends one end marker (out_valid low) if nothing is held.
// Throughput is one input request per cycle while each byte makes at most one
// push and out_stall lets results drain; a closing run plus a byte makes two
// pushes, and the end of a string sends its held bytes out one at a time, set by
// the single read port of the stack. A result passes the read register and
// then the output register. A two-entry command queue lets input continue
// during a stall. Reset clears the decode state, the queue and the stack,
// and drops any pending result.
// ----------------------------------------------------------------------------
`include "c_escape_string_decoder_defines.svh"

module c_escape_string_decoder import cesd_pkg::*; #(
  parameter int unsigned HOLD_DEPTH = 16
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] in_byte,
  input  logic       in_last,
  output logic       out_req_valid,
  input  logic       out_stall,
  output logic [7:0] out_byte,
  output logic       out_valid,
  output logic       out_last
);

  localparam int unsigned CW = $clog2(HOLD_DEPTH + 1);

  cmd_t          f_cmd, q_cmd;
  logic          f_push, q_full, q_valid, q_pop;
  mode_t         front_mode;
  logic [CW-1:0] hold_cnt;

  cesd_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_byte  (in_byte),
    .in_last  (in_last),
    .q_full   (q_full),
    .cmd_push (f_push),
    .cmd      (f_cmd),
    .mode     (front_mode)
  );

  cesd_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_en    (f_push),
    .wr_cmd   (f_cmd),
    .full     (q_full),
    .rd_en    (q_pop),
    .rd_valid (q_valid),
    .rd_cmd   (q_cmd)
  );

  cesd_back #(
    .HOLD_DEPTH (HOLD_DEPTH)
  ) u_back (
    .clk           (clk),
    .rst_n         (rst_n),
    .cmd_valid     (q_valid),
    .cmd           (q_cmd),
    .cmd_done      (q_pop),
    .out_req_valid (out_req_valid),
    .out_stall     (out_stall),
    .out_byte      (out_byte),
    .out_valid     (out_valid),
    .out_last      (out_last),
    .hold_cnt      (hold_cnt)
  );

  `CESD_ASSERT(a_hold_bound, hold_cnt <= CW'(HOLD_DEPTH), "Hold count exceeds the stack depth.")
  `CESD_ASSERT(a_marker_shape, out_req_valid && !out_valid |-> out_last && out_byte == 8'h00, "End marker is malformed.")
  `CESD_ASSERT_NEXT(a_last_clears, in_valid && !in_stall && in_last, front_mode == MODE_NORMAL, "Decoder not in normal mode after the last byte.")

endmodule

FILE: sv/cesd_front.sv
// ----------------------------------------------------------------------------
// C escape string decoder front end
// Accepts raw bytes, tracks escape and run state, and issues hold commands.
// ----------------------------------------------------------------------------
module cesd_front import cesd_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] in_byte,
  input  logic       in_last,
  input  logic       q_full,
  output logic       cmd_push,
  output cmd_t       cmd,
  output mode_t      mode
);

  mode_t      mode_r, mode_nxt;
  logic [7:0] run_r, run_nxt;
  logic       ostop_r, ostop_nxt;
  logic       accept;

  assign in_stall = q_full;
  assign accept   = in_valid && !q_full;
  assign cmd_push = accept;
  assign mode     = mode_r;

  always_comb begin
    logic [4:0] hx;
    logic       is_dig;
    logic       taken;
    hx        = hex_digit(in_byte);
    is_dig    = (in_byte >= CH_0) && (in_byte <= CH_9);
    taken     = 1'b0;
    mode_nxt  = mode_r;
    run_nxt   = run_r;
    ostop_nxt = ostop_r;
    cmd       = '0;
    cmd.pa_val = run_r;

    unique case (mode_r)
      MODE_OCTAL: begin
        if (is_dig) begin
          taken = 1'b1;
          if (!ostop_r) begin
            if (in_byte <= CH_7) begin
              run_nxt = {run_r[4:0], in_byte[2:0]};
            end else begin
              ostop_nxt = 1'b1;
            end
          end
        end else begin
          cmd.pa_en = 1'b1;
          mode_nxt  = MODE_NORMAL;
        end
      end
      MODE_HEX: begin
        if (hx[4]) begin
          taken   = 1'b1;
          run_nxt = {run_r[3:0], hx[3:0]};
        end else begin
          cmd.pa_en = 1'b1;
          mode_nxt  = MODE_NORMAL;
        end
      end
      MODE_NORMAL: begin
      end
      MODE_ESCAPE: begin
      end
    endcase

    if (!taken) begin
      if (mode_nxt == MODE_NORMAL) begin
        if (in_byte == CH_BSLASH) begin
          mode_nxt = MODE_ESCAPE;
        end else begin
          cmd.pb_en  = 1'b1;
          cmd.pb_val = in_byte;
        end
      end else begin
        mode_nxt = MODE_NORMAL;
        unique case (in_byte) inside
          CH_QUOTE, CH_BSLASH: begin
            cmd.pb_en  = 1'b1;
            cmd.pb_val = in_byte;
          end
          CH_N: begin
            cmd.pb_en  = 1'b1;
            cmd.pb_val = BYTE_NL;
          end
          CH_T: begin
            cmd.pb_en  = 1'b1;
            cmd.pb_val = BYTE_TAB;
          end
          CH_R: begin
          end
          CH_B: begin
            cmd.pop = 1'b1;
          end
          CH_X: begin
            mode_nxt = MODE_HEX;
            run_nxt  = '0;
          end
          [CH_0:CH_7]: begin
            mode_nxt  = MODE_OCTAL;
            ostop_nxt = 1'b0;
            run_nxt   = {5'd0, in_byte[2:0]};
          end
          [CH_8:CH_9]: begin
            mode_nxt  = MODE_OCTAL;
            ostop_nxt = 1'b1;
            run_nxt   = '0;
          end
          default: begin
          end
        endcase
      end
    end

    // An open run at the end of the string still delivers its value.
    if (in_last) begin
      if (mode_nxt == MODE_OCTAL || mode_nxt == MODE_HEX) begin
        cmd.pa_en  = 1'b1;
        cmd.pa_val = run_nxt;
      end
      cmd.flush = 1'b1;
      mode_nxt  = MODE_NORMAL;
      run_nxt   = '0;
      ostop_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r  <= MODE_NORMAL;
      run_r   <= '0;
      ostop_r <= 1'b0;
    end else if (accept) begin
      mode_r  <= mode_nxt;
      run_r   <= run_nxt;
      ostop_r <= ostop_nxt;
    end
  end

endmodule

FILE: sv/cesd_queue.sv
// ----------------------------------------------------------------------------
// C escape string decoder command queue
// Short FIFO that decouples the front end from the hold stack engine.
// ----------------------------------------------------------------------------
module cesd_queue import cesd_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic wr_en,
  input  cmd_t wr_cmd,
  output logic full,
  input  logic rd_en,
  output logic rd_valid,
  output cmd_t rd_cmd
);

  cmd_t            ent_r [Q_DEPTH];
  logic [Q_PW-1:0] wp_r;
  logic [Q_PW-1:0] rp_r;
  logic [Q_CW-1:0] cnt_r;

  assign full     = (cnt_r == Q_CW'(Q_DEPTH));
  assign rd_valid = (cnt_r != '0);
  assign rd_cmd   = ent_r[rp_r];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      ent_r[wp_r] <= wr_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (wr_en) begin
        wp_r <= (wp_r == Q_PW'(Q_DEPTH - 1)) ? '0 : wp_r + 1'b1;
      end
      if (rd_en) begin
        rp_r <= (rp_r == Q_PW'(Q_DEPTH - 1)) ? '0 : rp_r + 1'b1;
      end
      case ({wr_en, rd_en})
        2'b10:   cnt_r <= cnt_r + 1'b1;
        2'b01:   cnt_r <= cnt_r - 1'b1;
        default: cnt_r <= cnt_r;
      endcase
    end
  end

endmodule

FILE: sv/cesd_back.sv
// ----------------------------------------------------------------------------
// C escape string decoder back end
// Executes hold stack commands: push with overflow, delete and end flush.
// ----------------------------------------------------------------------------
module cesd_back import cesd_pkg::*; #(
  parameter int unsigned HOLD_DEPTH = 16,
  localparam int unsigned PW = (HOLD_DEPTH > 1) ? $clog2(HOLD_DEPTH) : 1,
  localparam int unsigned CW = $clog2(HOLD_DEPTH + 1)
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          cmd_valid,
  input  cmd_t          cmd,
  output logic          cmd_done,
  output logic          out_req_valid,
  input  logic          out_stall,
  output logic [7:0]    out_byte,
  output logic          out_valid,
  output logic          out_last,
  output logic [CW-1:0] hold_cnt
);

  logic [7:0]    mem [HOLD_DEPTH];
  logic [7:0]    rd_data_r;
  logic [PW-1:0] head_r, head_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic          a_done_r, b_done_r, p_done_r;
  logic          s1_vld_r, s1_mark_r, s1_last_r;
  logic          ov_r, obv_r, olast_r;
  logic [7:0]    ob_r;

  logic          full, out_take, s1_move, s1_free;
  logic          pend_a, pend_b, pend_p;
  logic          do_push, do_pop, do_fl, fire, rest, issue, mem_we;
  logic [7:0]    push_val;
  logic [PW-1:0] head_inc, tail, waddr;
  logic [CW:0]   tsum;

  assign full     = (cnt_r == CW'(HOLD_DEPTH));
  assign head_inc = (head_r == PW'(HOLD_DEPTH - 1)) ? '0 : head_r + 1'b1;
  assign tsum     = (CW+1)'(head_r) + (CW+1)'(cnt_r);
  assign tail     = (tsum >= (CW+1)'(HOLD_DEPTH)) ? PW'(tsum - (CW+1)'(HOLD_DEPTH))
                                                  : PW'(tsum);

  assign out_take = ov_r && !out_stall;
  assign s1_move  = s1_vld_r && (!ov_r || out_take);
  assign s1_free  = !s1_vld_r || s1_move;

  assign pend_a   = cmd.pa_en && !a_done_r;
  assign pend_b   = cmd.pb_en && !b_done_r;
  assign pend_p   = cmd.pop && !p_done_r;
  assign do_push  = cmd_valid && (pend_a || pend_b);
  assign do_pop   = cmd_valid && !pend_a && !pend_b && pend_p;
  assign do_fl    = cmd_valid && !pend_a && !pend_b && !pend_p && cmd.flush;
  assign push_val = pend_a ? cmd.pa_val : cmd.pb_val;

  always_comb begin
    if (do_push) begin
      fire = !full || s1_free;
    end else if (do_fl) begin
      fire = s1_free;
    end else begin
      fire = cmd_valid;
    end

    if (do_push && pend_a) begin
      rest = pend_b || pend_p || cmd.flush;
    end else if (do_push) begin
      rest = pend_p || cmd.flush;
    end else if (do_pop) begin
      rest = cmd.flush;
    end else if (do_fl) begin
      rest = (cnt_r > CW'(1));
    end else begin
      rest = 1'b0;
    end
  end

  assign cmd_done = fire && !rest;
  assign issue    = fire && ((do_push && full) || do_fl);
  assign mem_we   = fire && do_push;
  assign waddr    = full ? head_r : tail;

  always_comb begin
    head_nxt = head_r;
    cnt_nxt  = cnt_r;
    if (fire) begin
      if (do_push) begin
        if (full) begin
          head_nxt = head_inc;
        end else begin
          cnt_nxt = cnt_r + 1'b1;
        end
      end else if (do_pop || do_fl) begin
        if (cnt_r != '0) begin
          cnt_nxt = cnt_r - 1'b1;
          if (do_fl) begin
            head_nxt = head_inc;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[waddr] <= push_val;
    end
    if (issue) begin
      rd_data_r <= mem[head_r];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r   <= '0;
      cnt_r    <= '0;
      a_done_r <= 1'b0;
      b_done_r <= 1'b0;
      p_done_r <= 1'b0;
      s1_vld_r <= 1'b0;
      ov_r     <= 1'b0;
    end else begin
      head_r <= head_nxt;
      cnt_r  <= cnt_nxt;
      if (cmd_done) begin
        a_done_r <= 1'b0;
        b_done_r <= 1'b0;
        p_done_r <= 1'b0;
      end else if (fire) begin
        if (do_push && pend_a) begin
          a_done_r <= 1'b1;
        end
        if (do_push && !pend_a) begin
          b_done_r <= 1'b1;
        end
        if (do_pop) begin
          p_done_r <= 1'b1;
        end
      end
      if (issue) begin
        s1_vld_r <= 1'b1;
      end else if (s1_move) begin
        s1_vld_r <= 1'b0;
      end
      if (s1_move) begin
        ov_r <= 1'b1;
      end else if (out_take) begin
        ov_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (issue) begin
      s1_mark_r <= do_fl && (cnt_r == '0);
      s1_last_r <= do_fl && (cnt_r <= CW'(1));
    end
    if (s1_move) begin
      ob_r    <= s1_mark_r ? 8'h00 : rd_data_r;
      obv_r   <= !s1_mark_r;
      olast_r <= s1_last_r;
    end
  end

  assign out_req_valid = ov_r;
  assign out_byte      = ob_r;
  assign out_valid     = obv_r;
  assign out_last      = olast_r;
  assign hold_cnt      = cnt_r;

endmodule

FILE: sim/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// C escape string decoder testbench
// A short table of escaped strings, with a few results typed in, is followed
// by random strings that mix plain bytes with escapes and runs. Every
// accepted byte goes through a local decoder model whose results are queued
// and compared with each accepted result request. Both sides idle at random.
// The receiver also holds off for a long stretch while input keeps coming,
// and the sender twice waits for all results to drain.
// ----------------------------------------------------------------------------
module testbench import cesd_pkg::*; ();

  localparam int unsigned HOLD_DEPTH  = 16;
  localparam int          HOLD_CYCLES = 200;
  localparam int          IDLE_LIMIT  = 2000;
  localparam int          TAIL_CYCLES = 20;
  localparam int          NUM_ROWS    = 31;

  localparam logic [7:0] CH_3 = 8'h33;
  localparam logic [7:0] CH_G = 8'h67;
  localparam logic [7:0] CH_Q = 8'h71;

  typedef struct packed {
    logic [7:0] data;
    logic       valid;
    logic       last;
  } decoded_t;

  typedef struct packed {
    logic [7:0] data;
    logic       last;
  } raw_t;

  typedef struct packed {
    logic [7:0] data;
    logic       last;
    logic       typed;
    logic [7:0] exp_data;
    logic       exp_valid;
    logic       exp_last;
  } stim_row_t;

  localparam stim_row_t DIR_ROWS [NUM_ROWS] = '{
    '{8'h00,     1'b1, 1'b1, 8'h00, 1'b1, 1'b1},
    '{CH_BSLASH, 1'b1, 1'b1, 8'h00, 1'b0, 1'b1},
    '{CH_BSLASH, 1'b0, 1'b0, 8'h00, 1'b0, 1'b0},
    '{CH_B,      1'b0, 1'b0, 8'h00, 1'b0, 1'b0},
    '{8'hFF,     1'b0, 1'b0, 8'h00, 1'b0, 1'b0},
    '{CH_BSLASH, 1'b0, 1'b0, 8'h00, 1'b0, 1'b0},
    '{CH_N,      1'b0, 1'b0, 8'h00, 1'b0, 1'b0},
    '{CH_BSLASH, 1'b0, 1'b0, 8'h00, 1'b0, 1'b0},
    '{CH_T,      1'b0, 1'b0, 8'h00, 1'b0, 1'b0},
    '{CH_BSLASH, 1'b0, 1'b0, 8'h00, 1'b0, 1'b0},
    '{CH_QUOTE,  1'b0, 1'b0, 8'h00, 1'b0, 1'b0},
    '{CH_BSLASH, 1'b0, 1'b0, 8'h00, 1'b0, 1'b0},
    '{CH_BSLASH, 1'b0, 1'b0, 8'h00, 1'b0, 1'b0},
    '{CH_BSLASH, 1'b0, 1'b0, 8'h00, 1'b0, 1'b0},
    '{CH_R,      1'b0, 1'b0, 8'h00, 1'b0, 1'b0},
    '{CH_BSLASH, 1'b0, 1'b0, 8'h00, 1'b0, 1'b0},
    '{CH_Q,      1'b1, 1'b0, 8'h00, 1'b0, 1'b0},
    '{CH_BSLASH, 1'b0, 1'b0, 8'h00, 1'b0, 1'b0},
    '{CH_3,      1'b0, 1'b0, 8'h00, 1'b0, 1'b0},
    '{CH_7,      1'b0, 1'b0, 8'h00, 1'b0, 1'b0},
    '{CH_7,      1'b0, 1'b0, 8'h00, 1'b0, 1'b0},
    '{CH_9,      1'b0, 1'b0, 8'h00, 1'b0, 1'b0},
    '{CH_BSLASH, 1'b0, 1'b0, 8'h00, 1'b0, 1'b0},
    '{CH_X,      1'b0, 1'b0, 8'h00, 1'b0, 1'b0},
    '{CH_UF,     1'b0, 1'b0, 8'h00, 1'b0, 1'b0},
    '{CH_LA,     1'b0, 1'b0, 8'h00, 1'b0, 1'b0},
    '{CH_BSLASH, 1'b0, 1'b0, 8'h00, 1'b0, 1'b0},
    '{CH_8,      1'b0, 1'b0, 8'h00, 1'b0, 1'b0},
    '{CH_G,      1'b0, 1'b0, 8'h00, 1'b0, 1'b0},
    '{CH_BSLASH, 1'b0, 1'b0, 8'h00, 1'b0, 1'b0},
    '{CH_X,      1'b1, 1'b0, 8'h00, 1'b0, 1'b0}
  };

  localparam logic [7:0] SIMPLE_ESC [6] = '{CH_QUOTE, CH_N, CH_T, CH_BSLASH, CH_R, CH_B};

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       in_valid = 1'b0;
  logic       in_stall;
  logic [7:0] in_byte = 8'h00;
  logic       in_last = 1'b0;
  logic       out_req_valid;
  logic       out_stall = 1'b0;
  logic [7:0] out_byte;
  logic       out_valid;
  logic       out_last;

  bit         quiet = 1'b0;
  bit         hold_off_req = 1'b0;
  int         fail_count = 0;

  mode_t      dec_mode;
  logic [7:0] run_acc;
  logic       oct_halt;
  logic [7:0] held [HOLD_DEPTH];
  int         held_cnt;
  decoded_t   decoded_q [$];
  raw_t       str_q [$];

  c_escape_string_decoder #(.HOLD_DEPTH(HOLD_DEPTH)) DUT (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_byte       (in_byte),
    .in_last       (in_last),
    .out_req_valid (out_req_valid),
    .out_stall     (out_stall),
    .out_byte      (out_byte),
    .out_valid     (out_valid),
    .out_last      (out_last)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  function automatic int nibble_of(input logic [7:0] c);
    if (c >= CH_0 && c <= CH_9) return c - CH_0;
    if (c >= CH_LA && c <= CH_LF) return c - CH_LA + 10;
    if (c >= CH_UA && c <= CH_UF) return c - CH_UA + 10;
    return -1;
  endfunction

  task automatic clear_decoder();
    dec_mode = MODE_NORMAL;
    run_acc  = 8'h00;
    oct_halt = 1'b0;
    held_cnt = 0;
  endtask

  task automatic hold_push(input logic [7:0] b);
    int i;
    if (held_cnt >= HOLD_DEPTH) begin
      decoded_q.push_back('{held[0], 1'b1, 1'b0});
      for (i = 0; i < HOLD_DEPTH - 1; i++) held[i] = held[i + 1];
      held_cnt = HOLD_DEPTH - 1;
    end
    held[held_cnt] = b;
    held_cnt++;
  endtask

  task automatic decode_byte(input logic [7:0] b, input logic l);
    logic taken;
    int   nib;
    int   i;
    taken = 1'b0;
    if (dec_mode == MODE_OCTAL) begin
      if (b >= CH_0 && b <= CH_9) begin
        if (!oct_halt) begin
          if (b <= CH_7) run_acc = (run_acc << 3) + (b - CH_0);
          else oct_halt = 1'b1;
        end
        taken = 1'b1;
      end else begin
        hold_push(run_acc);
        dec_mode = MODE_NORMAL;
      end
    end else if (dec_mode == MODE_HEX) begin
      nib = nibble_of(b);
      if (nib >= 0) begin
        run_acc = (run_acc << 4) + 8'(nib);
        taken = 1'b1;
      end else begin
        hold_push(run_acc);
        dec_mode = MODE_NORMAL;
      end
    end

    if (!taken) begin
      if (dec_mode == MODE_NORMAL) begin
        if (b == CH_BSLASH) dec_mode = MODE_ESCAPE;
        else hold_push(b);
      end else begin
        dec_mode = MODE_NORMAL;
        case (b)
          CH_QUOTE:  hold_push(CH_QUOTE);
          CH_N:      hold_push(BYTE_NL);
          CH_T:      hold_push(BYTE_TAB);
          CH_BSLASH: hold_push(CH_BSLASH);
          CH_R:      ;
          CH_B: begin
            if (held_cnt > 0) held_cnt--;
          end
          CH_X: begin
            dec_mode = MODE_HEX;
            run_acc  = 8'h00;
          end
          default: begin
            if (b >= CH_0 && b <= CH_9) begin
              dec_mode = MODE_OCTAL;
              oct_halt = (b >= CH_8);
              run_acc  = oct_halt ? 8'h00 : b - CH_0;
            end
          end
        endcase
      end
    end

    if (l) begin
      if (dec_mode == MODE_OCTAL || dec_mode == MODE_HEX) hold_push(run_acc);
      if (held_cnt == 0) begin
        decoded_q.push_back('{8'h00, 1'b0, 1'b1});
      end else begin
        for (i = 0; i < held_cnt; i++)
          decoded_q.push_back('{held[i], 1'b1, logic'(i == held_cnt - 1)});
      end
      clear_decoder();
    end
  endtask

  // Offers one request and returns in the time step in which it is taken.
  task automatic send_item(input logic [7:0] b, input logic l);
    if (!quiet && $urandom_range(99) < 8) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(3, 1)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_byte  <= b;
    in_last  <= l;
    do @(posedge clk); while (in_stall);
  endtask

  function automatic logic [7:0] random_digit(input bit hex);
    int pick;
    if (!hex) begin
      if ($urandom_range(9) < 8) return CH_0 + 8'($urandom_range(7));
      return CH_8 + 8'($urandom_range(1));
    end
    pick = $urandom_range(21);
    if (pick < 10) return CH_0 + 8'(pick);
    if (pick < 16) return CH_LA + 8'(pick - 10);
    return CH_UA + 8'(pick - 16);
  endfunction

  task automatic build_string();
    int         n;
    int         k;
    int         j;
    int         kind;
    logic [7:0] b;
    n = ($urandom_range(9) == 0) ? $urandom_range(30, 12) : $urandom_range(8, 1);
    str_q.delete();
    for (k = 0; k < n; k++) begin
      kind = $urandom_range(99);
      if (kind < 45) begin
        b = 8'($urandom_range(255));
        if (b == CH_BSLASH) b = CH_UA;
        str_q.push_back('{b, 1'b0});
      end else if (kind < 60) begin
        str_q.push_back('{CH_BSLASH, 1'b0});
        str_q.push_back('{SIMPLE_ESC[$urandom_range(5)], 1'b0});
      end else if (kind < 72) begin
        str_q.push_back('{CH_BSLASH, 1'b0});
        for (j = $urandom_range(5, 1); j > 0; j--)
          str_q.push_back('{random_digit(1'b0), 1'b0});
      end else if (kind < 84) begin
        str_q.push_back('{CH_BSLASH, 1'b0});
        str_q.push_back('{CH_X, 1'b0});
        for (j = $urandom_range(4); j > 0; j--)
          str_q.push_back('{random_digit(1'b1), 1'b0});
      end else if (kind < 92) begin
        str_q.push_back('{CH_BSLASH, 1'b0});
        str_q.push_back('{8'($urandom_range(255)), 1'b0});
      end else begin
        str_q.push_back('{8'($urandom_range(255)), 1'b0});
      end
    end
    str_q[str_q.size() - 1].last = 1'b1;
  endtask

  task automatic run_strings(input int items);
    int   sent;
    raw_t r;
    sent = 0;
    while (sent < items) begin
      build_string();
      foreach (str_q[i]) begin
        r = str_q[i];
        send_item(r.data, r.last);
        decode_byte(r.data, r.last);
      end
      sent += str_q.size();
    end
  endtask

  always @(posedge clk) begin
    decoded_t want;
    if (rst_n && out_req_valid && !out_stall) begin
      if (decoded_q.size() == 0) begin
        $error("unexpected result request: out_byte %0h out_valid %0b out_last %0b",
               out_byte, out_valid, out_last);
        fail_count++;
      end else begin
        want = decoded_q.pop_front();
        if (out_byte !== want.data) begin
          $error("out_byte: expected %0h, got %0h", want.data, out_byte);
          fail_count++;
        end
        if (out_valid !== want.valid) begin
          $error("out_valid: expected %0b, got %0b", want.valid, out_valid);
          fail_count++;
        end
        if (out_last !== want.last) begin
          $error("out_last: expected %0b, got %0b", want.last, out_last);
          fail_count++;
        end
      end
    end
  end

  initial begin
    forever begin
      @(posedge clk);
      if (hold_off_req) begin
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_off_req = 1'b0;
      end else if (!quiet && $urandom_range(99) < 8) begin
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  initial begin
    int idle_cycles;
    idle_cycles = 0;
    while (idle_cycles < IDLE_LIMIT) begin
      @(posedge clk);
      if ((in_valid && !in_stall) || (out_req_valid && !out_stall)) idle_cycles = 0;
      else idle_cycles++;
    end
    $display("Test completed with failures");
    $finish;
  end

  initial begin
    stim_row_t row;
    int        n;
    clear_decoder();
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    for (int r = 0; r < NUM_ROWS; r++) begin
      row = DIR_ROWS[r];
      send_item(row.data, row.last);
      n = decoded_q.size();
      decode_byte(row.data, row.last);
      if (row.typed) begin
        while (decoded_q.size() > n) void'(decoded_q.pop_back());
        decoded_q.push_back('{row.exp_data, row.exp_valid, row.exp_last});
      end
    end

    run_strings(130);

    in_valid <= 1'b0;
    while (decoded_q.size() != 0) @(posedge clk);

    hold_off_req = 1'b1;
    run_strings(90);

    quiet = 1'b1;
    run_strings(90);
    quiet = 1'b0;

    run_strings(90);

    in_valid <= 1'b0;
    while (decoded_q.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
    if (fail_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

FILE: files.f
+incdir+sv
sv/cesd_pkg.sv
sv/cesd_front.sv
sv/cesd_queue.sv
sv/cesd_back.sv
sv/c_escape_string_decoder.sv
sim/testbench.sv
